>>> rtl/core/shad_pkg.sv
`timescale 1ns / 1ps
package shad_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  byte_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTES,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// byte source while filling the block
	typedef enum logic [1:0] {
		PH_MSG,
		PH_PAD80,
		PH_ZERO,
		PH_LEN
	} phase_t;

	typedef struct packed {
		logic  put;
		byte_t din;
		logic  step;
	} sched_ctrl_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       add;
		logic       init;
		logic [5:0] rnd;
	} round_ctrl_t;

	localparam byte_t      PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LAST_RND  = 6'd63;
	localparam logic [2:0] MAX_BYTES = 3'd4;
	localparam logic [2:0] LAST_IDX  = 3'd7;

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t big_s0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_s1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_s0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_s1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

>>> rtl/core/sha256_message_digest_unit.sv
`timescale 1ns / 1ps
// Bytes enter one per cycle, except while a full block compresses. Input item with n
// valid bytes: accept, its bytes, end check. Each full 64-byte block: 64 rounds of the
// shared round unit + chain add. Last item: a step to start padding, padding bytes with
// a pause at the length position, 8 digest words, one per cycle while out_ready is high.
// Not ready while an item or its padding, compression or digest output is in progress.
// Reset (arst_n low, async): idle, chain = initial hash values, length and fill cleared.
module sha256_message_digest_unit import shad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	state_t      state_q, state_d;
	phase_t      phase_q, phase_d;
	word_t       data_q;
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [2:0]  bidx_q, bidx_d;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic        fin_q, fin_d;
	logic [2:0]  oidx_q;
	logic        out_valid_q;
	word_t       digest_q;
	logic [2:0]  windex_q;
	logic        lastw_q;

	logic        accept, put, msg_byte, item_done, ld_out, wrap_up;
	byte_t       put_byte, msg_sel, len_sel;
	sched_ctrl_t sctl;
	round_ctrl_t rctl;
	word_t       w;
	word_t       chain [8];

	shad_sched u_sched (
		.clk  (clk),
		.ctrl (sctl),
		.w    (w)
	);

	shad_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rctl),
		.w      (w),
		.chain  (chain)
	);

	assign accept = in_valid && in_ready;

	always_comb begin
		case (bidx_q[1:0])
			2'd0:    msg_sel = data_q[31:24];
			2'd1:    msg_sel = data_q[23:16];
			2'd2:    msg_sel = data_q[15:8];
			default: msg_sel = data_q[7:0];
		endcase
		len_sel = bits_q[{~bidx_q, 3'b000} +: 8];
	end

	// output / datapath control
	always_comb begin
		in_ready  = 1'b0;
		put       = 1'b0;
		put_byte  = '0;
		msg_byte  = 1'b0;
		item_done = 1'b0;
		phase_d   = phase_q;
		bidx_d    = bidx_q;
		fin_d     = fin_q;
		ld_out    = 1'b0;
		wrap_up   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				bidx_d   = '0;
			end
			ST_BYTES: begin
				case (phase_q)
					PH_MSG: begin
						if (bidx_q < cnt_q) begin
							put      = 1'b1;
							put_byte = msg_sel;
							msg_byte = 1'b1;
							bidx_d   = bidx_q + 3'd1;
						end else if (last_q) begin
							phase_d = PH_PAD80;
						end else begin
							item_done = 1'b1;
						end
					end
					PH_PAD80: begin
						put      = 1'b1;
						put_byte = PAD_BYTE;
						phase_d  = PH_ZERO;
					end
					PH_ZERO: begin
						if (fill_q == LEN_POS) begin
							phase_d = PH_LEN;
							bidx_d  = '0;
						end else begin
							put = 1'b1;
						end
					end
					PH_LEN: begin
						put      = 1'b1;
						put_byte = len_sel;
						bidx_d   = bidx_q + 3'd1;
						if (bidx_q == LAST_IDX) begin
							fin_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ST_OUT: begin
				ld_out  = !out_valid_q || out_ready;
				wrap_up = ld_out && (oidx_q == LAST_IDX);
				if (wrap_up) begin
					phase_d = PH_MSG;
					fin_d   = 1'b0;
				end
			end
			default: ;
		endcase

		sctl.put  = put;
		sctl.din  = put_byte;
		sctl.step = (state_q == ST_ROUND);

		rctl.load = put && (fill_q == LAST_POS);
		rctl.step = (state_q == ST_ROUND);
		rctl.add  = (state_q == ST_ADD);
		rctl.init = wrap_up;
		rctl.rnd  = rnd_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_BYTES;
				end
			end
			ST_BYTES: begin
				if (put && (fill_q == LAST_POS)) begin
					state_d = ST_ROUND;
				end else if (item_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_RND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = fin_q ? ST_OUT : ST_BYTES;
			end
			ST_OUT: begin
				if (wrap_up) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_MSG;
			bidx_q      <= '0;
			fill_q      <= '0;
			bits_q      <= '0;
			rnd_q       <= '0;
			fin_q       <= 1'b0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			bidx_q  <= bidx_d;
			fin_q   <= fin_d;
			if (put) begin
				fill_q <= fill_q + 6'd1;
			end
			if (wrap_up) begin
				bits_q <= '0;
			end else if (msg_byte) begin
				bits_q <= bits_q + 64'd8;
			end
			if (rctl.load) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
				oidx_q      <= wrap_up ? 3'd0 : oidx_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= data_word;
			cnt_q  <= (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
			last_q <= last;
		end
		if (ld_out) begin
			digest_q <= chain[oidx_q];
			windex_q <= oidx_q;
			lastw_q  <= (oidx_q == LAST_IDX);
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = windex_q;
	assign last_word   = lastw_q;

	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_up |=> (bits_q == '0 && fill_q == '0 && state_q == ST_IDLE))
		else $error("length or fill not cleared after digest");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=>
			(out_valid && word_index == $past(word_index) + 3'd1))
		else $error("digest words not consecutive");

	a_len_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BYTES && phase_q == PH_LEN) |-> (fill_q >= LEN_POS))
		else $error("length bytes outside block tail");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_word) |-> (word_index == LAST_IDX))
		else $error("last word flag on wrong index");

endmodule

>>> rtl/core/shad_sched.sv
`timescale 1ns / 1ps
// Block buffer and message schedule in one 16-word shift line.
// Filling shifts one byte in at the bottom; each round shifts one word out
// of the top and appends the next schedule word.
module shad_sched import shad_pkg::*; (
	input  logic        clk,
	input  sched_ctrl_t ctrl,
	output word_t       w
);

	logic [511:0] win_q;
	word_t        w_new;

	// window word i sits at bits 511-32*i down
	assign w_new = small_s1(win_q[63:32]) + win_q[223:192]
		+ small_s0(win_q[479:448]) + win_q[511:480];
	assign w = win_q[511:480];

	always_ff @(posedge clk) begin
		if (ctrl.put) begin
			win_q <= {win_q[503:0], ctrl.din};
		end else if (ctrl.step) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

>>> rtl/core/shad_round.sv
`timescale 1ns / 1ps
// Round unit: working variables a..h, one round per cycle, and the chain.
module shad_round import shad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  round_ctrl_t ctrl,
	input  word_t       w,
	output word_t       chain [8]
);

	word_t v_q [8];
	word_t chain_q [8];
	word_t t1, t2;

	always_comb begin
		t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K_TAB[ctrl.rnd] + w;
		t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= chain_q;
		end else if (ctrl.step) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= IV_TAB;
		end else if (ctrl.init) begin
			chain_q <= IV_TAB;
		end else if (ctrl.add) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	assign chain = chain_q;

endmodule

>>> bench/tb_sha256_message_digest_unit.sv
`timescale 1ns / 1ps
module tb_sha256_message_digest_unit import shad_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 300;
	localparam int LONG_HOLD   = 600;

	typedef struct {
		word_t      data;
		logic [2:0] cnt;
		logic       fin;
		bit         drain_first;   // wait for all digests before offering this one
	} msg_word_t;

	typedef struct {
		word_t      value;
		logic [2:0] idx;
		logic       fin;
	} digest_t;

	typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	const word_t round_const [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	const word_t hash_iv [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// message lengths in bytes around the padding and block limits
	const int boundary_len [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_message_digest_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always #4 clk = ~clk;

	msg_word_t  msg_words [$];
	digest_t    pending_digest [$];
	int         fail_count    = 0;
	int         cycle_count   = 0;
	int         words_queued  = 0;
	int         words_offered = 0;
	int         words_taken   = 0;
	int         results_seen  = 0;
	int         burst_left    = 0;
	int         gap_left      = 0;
	int         sink_span     = 0;
	int         hold_left     = 0;
	bit         hold_used     = 1'b0;
	bit         run_go        = 1'b0;
	sink_mode_t sink_mode     = SINK_OPEN;
	logic [15:0] sink_pattern = '1;

	// running hash state
	word_t       chain_h [8];
	word_t       blk_w [16];
	int unsigned fill_cnt;
	logic [63:0] msg_bits;

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void clear_hash();
		for (int i = 0; i < 8; i++)
			chain_h[i] = hash_iv[i];
		fill_cnt = 0;
		msg_bits = '0;
	endfunction

	function automatic void compress_block();
		word_t sched [64];
		word_t v [8];
		word_t t1, t2, s0, s1;
		for (int j = 0; j < 16; j++)
			sched[j] = blk_w[j];
		for (int j = 16; j < 64; j++) begin
			s0 = rotr(sched[j-15], 7) ^ rotr(sched[j-15], 18) ^ (sched[j-15] >> 3);
			s1 = rotr(sched[j-2], 17) ^ rotr(sched[j-2], 19) ^ (sched[j-2] >> 10);
			sched[j] = s1 + sched[j-7] + s0 + sched[j-16];
		end
		for (int j = 0; j < 8; j++)
			v[j] = chain_h[j];
		for (int j = 0; j < 64; j++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[j] + sched[j];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			chain_h[j] += v[j];
	endfunction

	function automatic void append_byte(logic [7:0] b);
		int unsigned pos;
		int unsigned sh;
		pos = fill_cnt;
		sh = 24 - 8 * (pos % 4);
		// first byte of a word clears the rest of it
		if (pos % 4 == 0)
			blk_w[pos / 4] = word_t'(b) << sh;
		else
			blk_w[pos / 4] |= word_t'(b) << sh;
		fill_cnt = pos + 1;
		if (fill_cnt == 64) begin
			compress_block();
			fill_cnt = 0;
		end
	endfunction

	function automatic void absorb_word(word_t data, logic [2:0] cnt, logic fin);
		int n;
		logic [63:0] len;
		digest_t d;
		n = (cnt > 4) ? 4 : cnt;
		for (int i = 0; i < n; i++) begin
			append_byte(data[31 - 8*i -: 8]);
			msg_bits += 64'd8;
		end
		if (fin) begin
			len = msg_bits;
			append_byte(8'h80);
			while (fill_cnt != 56)
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(len[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				d.value = chain_h[i];
				d.idx = 3'(i);
				d.fin = (i == 7);
				pending_digest.push_back(d);
			end
			clear_hash();
		end
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		fail_count++;
	endtask

	task automatic queue_word(word_t data, logic [2:0] cnt, logic fin, bit drain);
		msg_word_t w;
		w.data = data;
		w.cnt = cnt;
		w.fin = fin;
		w.drain_first = drain;
		msg_words.push_back(w);
		if (cnt != 0 || fin)
			words_queued++;
	endtask

	// well-formed message of nbytes with random content and garbage in unused bits
	task automatic queue_message(int nbytes, bit drain);
		int full;
		int rem;
		bit end_on_full;
		bit first;
		full = nbytes / 4;
		rem = nbytes % 4;
		end_on_full = (rem == 0 && full > 0 && $urandom_range(0, 1) == 1);
		first = drain;
		for (int i = 0; i < full; i++) begin
			queue_word($urandom, 3'd4, end_on_full && i == full - 1, first);
			first = 1'b0;
		end
		if (!end_on_full)
			queue_word($urandom, rem[2:0], 1'b1, first);
	endtask

	// sender: bursts of items with random gaps
	always @(negedge clk) begin
		msg_word_t cur;
		if (!run_go) begin
			in_valid <= 1'b0;
		end else if (in_valid && words_taken != words_offered) begin
			// hold the current item until accepted
		end else if (gap_left != 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (msg_words.size() == 0 ||
				(msg_words[0].drain_first && pending_digest.size() != 0)) begin
			in_valid <= 1'b0;
		end else begin
			cur = msg_words.pop_front();
			data_word <= cur.data;
			byte_count <= cur.cnt;
			last <= cur.fin;
			in_valid <= 1'b1;
			words_offered <= words_offered + 1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			end
		end
	end

	// long receiver hold-off while a digest is waiting
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && out_valid && results_seen >= 24) begin
			hold_left <= LONG_HOLD;
			hold_used <= 1'b1;
		end
	end

	// receiver: stall pattern changes every stretch
	always @(negedge clk) begin
		logic rdy;
		if (!run_go) begin
			out_ready <= 1'b0;
		end else begin
			if (sink_span == 0) begin
				sink_span = $urandom_range(16, 96);
				sink_pattern = 16'($urandom);
				case ($urandom_range(0, 2))
					0: sink_mode = SINK_OPEN;
					1: sink_mode = SINK_RANDOM;
					default: sink_mode = SINK_PATTERN;
				endcase
			end else begin
				sink_span--;
			end
			case (sink_mode)
				SINK_OPEN: rdy = 1'b1;
				SINK_RANDOM: rdy = ($urandom_range(0, 2) != 0);
				default: rdy = sink_pattern[sink_span % 16];
			endcase
			out_ready <= rdy && (hold_left == 0);
		end
	end

	// results are checked before new items are absorbed
	always @(posedge clk) begin
		digest_t d;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (pending_digest.size() == 0) begin
					report_mismatch($sformatf("unexpected digest word %h index %0d",
						digest_word, word_index));
				end else begin
					d = pending_digest.pop_front();
					if (digest_word !== d.value)
						report_mismatch($sformatf("digest_word %h, want %h (index %0d)",
							digest_word, d.value, d.idx));
					if (word_index !== d.idx)
						report_mismatch($sformatf("word_index %0d, want %0d",
							word_index, d.idx));
					if (last_word !== d.fin)
						report_mismatch($sformatf("last_word %b, want %b at index %0d",
							last_word, d.fin, d.idx));
				end
			end
			if (in_valid && in_ready) begin
				words_taken <= words_taken + 1;
				absorb_word(data_word, byte_count, last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sha256_message_digest_unit failed");
			$finish;
		end
	end

	initial begin
		int len;
		int nw;
		int sel;
		bit drain;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		last = 1'b0;
		out_ready = 1'b0;
		clear_hash();

		// empty message
		queue_word($urandom, 3'd0, 1'b1, 1'b0);
		// "abc" with a junk byte below the valid ones
		queue_word(32'h616263ff, 3'd3, 1'b1, 1'b0);
		// mixed message: zero-byte word, saturated count, short word mid-message
		queue_word(32'hffffffff, 3'd4, 1'b0, 1'b0);
		queue_word(32'h00000000, 3'd0, 1'b0, 1'b0);
		queue_word(32'h12345678, 3'd7, 1'b0, 1'b0);
		queue_word(32'hab5a5a5a, 3'd1, 1'b0, 1'b0);
		queue_word(32'hc3c3c3c3, 3'd2, 1'b0, 1'b0);
		queue_word(32'hffffffff, 3'd5, 1'b1, 1'b0);
		queue_word(32'h00000000, 3'd4, 1'b1, 1'b0);
		queue_word(32'hffffffff, 3'd6, 1'b1, 1'b0);
		queue_word(32'h80000000, 3'd2, 1'b1, 1'b0);
		// zero-byte last right after a full word
		queue_word(32'h01234567, 3'd4, 1'b0, 1'b0);
		queue_word(32'h89abcdef, 3'd0, 1'b1, 1'b0);

		len = 0;
		while (words_queued < 235) begin
			drain = (len == 0) || ($urandom_range(0, 15) == 0);
			len = 1;
			if ($urandom_range(0, 9) < 7) begin
				sel = $urandom_range(0, 19);
				if (sel < 4)
					queue_message(boundary_len[$urandom_range(0, 8)], drain);
				else if (sel == 4)
					queue_message($urandom_range(65, 200), drain);
				else
					queue_message($urandom_range(0, 40), drain);
			end else begin
				nw = $urandom_range(1, 12);
				for (int k = 0; k < nw; k++)
					queue_word($urandom, 3'($urandom_range(0, 7)), k == nw - 1,
						drain && k == 0);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		run_go = 1'b1;

		while (msg_words.size() != 0 || words_taken != words_offered ||
				pending_digest.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("tb_sha256_message_digest_unit passed");
		else
			$display("tb_sha256_message_digest_unit failed");
		$finish;
	end

endmodule
